// ----- rtl/core/utf16_to_utf8_transcoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top_defines.svh
// Assertion macros used by the transcoder top module.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked during reset.
`define U16U8_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, active during reset as well.
`define U16U8_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define U16U8_ASSERT(label, clk, rst, prop, msg)
`define U16U8_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/core/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and result codes of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_OK    = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic       high_pending;
      logic [9:0] high_bits;
      logic       name_finished;
   } state_type;

   // Results caused by one unit: up to four bytes, then an optional status.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      nbytes;
      logic            has_status;
      logic [1:0]      status;
   } run_type;

endpackage

`default_nettype wire

// ----- rtl/core/u16u8_decode.sv -----
// ----------------------------------------------------------------------------
// u16u8_decode
// Surrogate tracking and UTF-8 encoding of one code unit.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_decode (
   input  wire logic [15:0]         code_unit,
   input  wire logic                final_unit,
   input  wire u16u8_pkg::state_type state_cur,
   output u16u8_pkg::state_type     state_nxt,
   output u16u8_pkg::run_type       run
);
   import u16u8_pkg::*;

   logic        is_high;
   logic        is_low;
   logic        ended;
   logic        enc;
   logic [1:0]  status;
   logic [20:0] cp;

   always_comb begin
      is_high   = (code_unit[15:10] == 6'b110110);
      is_low    = (code_unit[15:10] == 6'b110111);
      state_nxt = state_cur;
      run       = '0;
      ended     = 1'b0;
      enc       = 1'b0;
      status    = KIND_OK;
      cp        = '0;

      if (state_cur.name_finished) begin
         if (final_unit) begin
            state_nxt.name_finished = 1'b0;
         end
      end else begin
         if (state_cur.high_pending) begin
            state_nxt.high_pending = 1'b0;
            state_nxt.high_bits    = '0;
            if (is_low) begin
               cp  = 21'h10000 + {1'b0, state_cur.high_bits, code_unit[9:0]};
               enc = 1'b1;
            end else begin
               status = KIND_ERROR;
               ended  = 1'b1;
            end
         end else if (code_unit == 16'h0000) begin
            ended = 1'b1;
         end else if (is_high) begin
            if (final_unit) begin
               status = KIND_ERROR;
               ended  = 1'b1;
            end else begin
               state_nxt.high_pending = 1'b1;
               state_nxt.high_bits    = code_unit[9:0];
            end
         end else if (is_low) begin
            status = KIND_ERROR;
            ended  = 1'b1;
         end else begin
            cp  = {5'd0, code_unit};
            enc = 1'b1;
         end

         if (final_unit) begin
            ended = 1'b1;
         end

         if (ended) begin
            run.has_status          = 1'b1;
            run.status              = status;
            state_nxt.high_pending  = 1'b0;
            state_nxt.high_bits     = '0;
            state_nxt.name_finished = !final_unit;
         end
      end

      if (enc) begin
         if (cp[20:7] == '0) begin
            run.nbytes  = 3'd1;
            run.data[0] = {1'b0, cp[6:0]};
         end else if (cp[20:11] == '0) begin
            run.nbytes  = 3'd2;
            run.data[0] = {3'b110, cp[10:6]};
            run.data[1] = {2'b10, cp[5:0]};
         end else if (cp[20:16] == '0) begin
            run.nbytes  = 3'd3;
            run.data[0] = {4'b1110, cp[15:12]};
            run.data[1] = {2'b10, cp[11:6]};
            run.data[2] = {2'b10, cp[5:0]};
         end else begin
            run.nbytes  = 3'd4;
            run.data[0] = {5'b11110, cp[20:18]};
            run.data[1] = {2'b10, cp[17:12]};
            run.data[2] = {2'b10, cp[11:6]};
            run.data[3] = {2'b10, cp[5:0]};
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf16_to_utf8_transcoder_top.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 name buffer to UTF-8 byte stream with end-of-name status.
// ----------------------------------------------------------------------------
// An accepted code unit sits in an input register, is decoded combinationally
// into a run of one to five results (bytes, then a status where the name
// ends), and that run is registered and leaves on the rsp_ channel at one
// result per cycle while rsp_ready is high. A run holds 1 to 3 bytes for a
// BMP character or 4 for a surrogate pair, plus one status where the name
// ends. Units that yield nothing (a stored high surrogate, units after the
// end of the name) never occupy the result channel. The next unit is taken
// while the current run drains, so the result channel sets throughput.
`default_nettype none
`include "utf16_to_utf8_transcoder_top_defines.svh"

module utf16_to_utf8_transcoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_final_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic             rsp_last_of_run
);
   import u16u8_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [15:0] in_unit_ff;
   logic        in_final_ff;
   state_type   state_ff;
   state_type   state_in;
   logic        run_valid_ff;
   logic        run_valid_in;
   run_type     run_ff;
   run_type     run_new;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;
   logic [2:0]  total;
   logic        run_has;
   logic        run_free;
   logic        move;

   u16u8_decode u_decode (
      .code_unit  (in_unit_ff),
      .final_unit (in_final_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .run        (run_new)
   );

   assign total           = run_ff.nbytes + {2'd0, run_ff.has_status};
   assign rsp_valid       = run_valid_ff;
   assign rsp_last_of_run = (idx_ff == total - 3'd1);
   assign rsp_kind        = (idx_ff < run_ff.nbytes) ? KIND_DATA : run_ff.status;
   assign rsp_out_byte    = (idx_ff < run_ff.nbytes) ? run_ff.data[idx_ff[1:0]] : 8'h00;

   assign run_has   = (run_new.nbytes != 3'd0) || run_new.has_status;
   assign run_free  = !run_valid_ff || (rsp_ready && rsp_last_of_run);
   assign move      = in_valid_ff && (!run_has || run_free);
   assign req_ready = !in_valid_ff || move;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      run_valid_in = run_valid_ff;
      idx_in       = idx_ff;
      if (move && run_has) begin
         run_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (run_valid_ff && rsp_ready) begin
         if (rsp_last_of_run) begin
            run_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         run_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         run_valid_ff <= run_valid_in;
         idx_ff       <= idx_in;
         if (move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_unit_ff  <= req_code_unit;
         in_final_ff <= req_final_unit;
      end
      if (move && run_has) begin
         run_ff <= run_new;
      end
   end

   `U16U8_ASSERT(a_idx_in_run, clock, reset, run_valid_ff |-> (idx_ff < total), "result index past end of run")
   `U16U8_ASSERT(a_status_last, clock, reset, (rsp_valid && rsp_kind != KIND_DATA) |-> rsp_last_of_run, "status result not last of run")
   `U16U8_ASSERT(a_state_excl, clock, reset, !(state_ff.high_pending && state_ff.name_finished), "high surrogate pending after end of name")
   `U16U8_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (!run_valid_ff && !in_valid_ff), "block not idle after reset")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 to UTF-8 name transcoder.
// ----------------------------------------------------------------------------
// Code units go in from a queue of pending items, and each accepted item runs
// through a behavioral transcoder that queues the bytes and end-of-name
// status it must produce. Every rsp_ item is checked field by field against
// the oldest queued result. A directed set covers the encoding boundaries,
// surrogate pairs and each kind of surrogate error. Random name buffers
// follow under several sender and receiver idling patterns, including a long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

   import u16u8_pkg::*;

   typedef struct {
      logic [15:0] unit;
      logic        fin;
   } unit_item_type;

   typedef struct {
      logic [7:0] ob;
      logic [1:0] kind;
      logic       last;
   } utf8_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = 16'h0000;
   logic        req_final_unit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_kind;
   logic        rsp_last_of_run;

   unit_item_type pend_units_q[$];
   utf8_res_type  utf8_exp_q[$];
   utf8_res_type  run_q[$];

   // transcoder state as predicted
   logic       pend_high = 1'b0;
   logic [9:0] pend_bits = 10'd0;
   logic       name_done = 1'b0;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_request = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   bit  req_took = 1'b0;

   int  units_sent = 0;
   int  results_checked = 0;
   int  ok_seen = 0;
   int  err_seen = 0;
   int  mismatches = 0;

   utf16_to_utf8_transcoder_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_final_unit  (req_final_unit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function void add_result(input logic [7:0] ob, input logic [1:0] kind);
      utf8_res_type r;
      r.ob = ob;
      r.kind = kind;
      r.last = 1'b0;
      run_q = {run_q, r};
   endfunction

   task automatic predict_utf8(input logic [15:0] u, input logic fin);
      logic         is_hi;
      logic         is_lo;
      logic         ended;
      logic         emit;
      logic [1:0]   status;
      logic [20:0]  cp;
      utf8_res_type r;
      is_hi = (u >= 16'hD800) && (u <= 16'hDBFF);
      is_lo = (u >= 16'hDC00) && (u <= 16'hDFFF);
      ended = 1'b0;
      emit = 1'b0;
      status = KIND_OK;
      cp = {5'd0, u};
      run_q.delete();
      if (name_done) begin
         if (fin)
            name_done = 1'b0;
         return;
      end
      if (pend_high) begin
         pend_high = 1'b0;
         if (is_lo) begin
            cp = 21'h10000 + {1'b0, pend_bits, u[9:0]};
            emit = 1'b1;
         end else begin
            status = KIND_ERROR;
            ended = 1'b1;
         end
         pend_bits = 10'd0;
      end else if (u == 16'h0000) begin
         ended = 1'b1;
      end else if (is_hi) begin
         if (fin) begin
            status = KIND_ERROR;
            ended = 1'b1;
         end else begin
            pend_high = 1'b1;
            pend_bits = u[9:0];
         end
      end else if (is_lo) begin
         status = KIND_ERROR;
         ended = 1'b1;
      end else begin
         emit = 1'b1;
      end

      if (emit) begin
         if (cp <= 21'h7F) begin
            add_result(cp[7:0], KIND_DATA);
         end else if (cp <= 21'h7FF) begin
            add_result({3'b110, cp[10:6]}, KIND_DATA);
            add_result({2'b10, cp[5:0]}, KIND_DATA);
         end else if (cp <= 21'hFFFF) begin
            add_result({4'b1110, cp[15:12]}, KIND_DATA);
            add_result({2'b10, cp[11:6]}, KIND_DATA);
            add_result({2'b10, cp[5:0]}, KIND_DATA);
         end else begin
            add_result({5'b11110, cp[20:18]}, KIND_DATA);
            add_result({2'b10, cp[17:12]}, KIND_DATA);
            add_result({2'b10, cp[11:6]}, KIND_DATA);
            add_result({2'b10, cp[5:0]}, KIND_DATA);
         end
      end

      if (fin)
         ended = 1'b1;
      if (ended) begin
         add_result(8'h00, status);
         pend_high = 1'b0;
         pend_bits = 10'd0;
         name_done = !fin;
      end

      if (run_q.size() > 0)
         run_q[run_q.size() - 1].last = 1'b1;
      while (run_q.size() > 0) begin
         r = run_q.pop_front();
         utf8_exp_q = {utf8_exp_q, r};
      end
   endtask

   // input side: predict on acceptance; result side: check against oldest
   always @(posedge clock) begin
      utf8_res_type e;
      req_took = !reset && req_valid && req_ready;
      if (req_took) begin
         units_sent++;
         predict_utf8(req_code_unit, req_final_unit);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (utf8_exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item byte=%h kind=%0d last=%b", $realtime,
                  rsp_out_byte, rsp_kind, rsp_last_of_run);
         end else begin
            e = utf8_exp_q.pop_front();
            if (e.kind == KIND_OK)
               ok_seen++;
            if (e.kind == KIND_ERROR)
               err_seen++;
            if (rsp_out_byte !== e.ob || rsp_kind !== e.kind || rsp_last_of_run !== e.last)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch exp byte=%h kind=%0d last=%b got byte=%h kind=%0d last=%b",
                     $realtime, e.ob, e.kind, e.last, rsp_out_byte, rsp_kind, rsp_last_of_run);
            end
         end
      end
   end

   // sender
   always @(negedge clock) begin
      unit_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pend_units_q.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            it = pend_units_q.pop_front();
            req_valid <= 1'b1;
            req_code_unit <= it.unit;
            req_final_unit <= it.fin;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = 300;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function void add_unit(input logic [15:0] unit, input logic fin);
      unit_item_type it;
      it.unit = unit;
      it.fin = fin;
      pend_units_q = {pend_units_q, it};
   endfunction

   // one buffer: mostly well-formed text, some noise, padding after the end
   task automatic gen_name_buffer(output int useful);
      int          slots;
      int          i;
      int          r;
      logic        done;
      logic [15:0] u;
      slots = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
      done = 1'b0;
      useful = 0;
      i = 0;
      while (i < slots) begin
         if (done) begin
            useful++;
            add_unit(16'($urandom), i == slots - 1);
         end else begin
            useful++;
            r = $urandom_range(0, 99);
            if (r < 10) begin
               u = 16'($urandom);
               add_unit(u, i == slots - 1);
               if (u == 16'h0000 || (u >= 16'hDC00 && u <= 16'hDFFF))
                  done = 1'b1;
            end else if (r < 18) begin
               add_unit(16'h0000, i == slots - 1);
               done = 1'b1;
            end else if (r < 43) begin
               add_unit(16'($urandom_range(1, 16'h7F)), i == slots - 1);
            end else if (r < 58) begin
               add_unit(16'($urandom_range(16'h80, 16'h7FF)), i == slots - 1);
            end else if (r < 78) begin
               if ($urandom_range(0, 1))
                  u = 16'($urandom_range(16'h800, 16'hD7FF));
               else
                  u = 16'($urandom_range(16'hE000, 16'hFFFF));
               add_unit(u, i == slots - 1);
            end else begin
               add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), i == slots - 1);
               if (i + 1 < slots) begin
                  i++;
                  useful++;
                  add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), i == slots - 1);
               end
            end
         end
         i++;
      end
   endtask

   task automatic drain_all();
      while (pend_units_q.size() != 0 || req_valid || utf8_exp_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int sidle, input int rstall, input int nunits,
                            input bit long_hold);
      int total;
      int n;
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      total = 0;
      while (total < nunits) begin
         gen_name_buffer(n);
         total += n;
      end
      if (long_hold)
         hold_request++;
      drain_all();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // encoding boundaries and surrogate cases
      add_unit(16'h0041, 1'b0);
      add_unit(16'h007F, 1'b0);
      add_unit(16'h0080, 1'b0);
      add_unit(16'h07FF, 1'b0);
      add_unit(16'h0800, 1'b0);
      add_unit(16'hD7FF, 1'b0);
      add_unit(16'hE000, 1'b0);
      add_unit(16'hFFFF, 1'b0);
      add_unit(16'hD800, 1'b0);
      add_unit(16'hDC00, 1'b0);
      add_unit(16'hDBFF, 1'b0);
      add_unit(16'hDFFF, 1'b0);
      add_unit(16'hDC00, 1'b0);
      add_unit(16'h1234, 1'b0);
      add_unit(16'h0000, 1'b1);
      add_unit(16'h0001, 1'b0);
      add_unit(16'h0000, 1'b0);
      add_unit(16'hABCD, 1'b1);
      add_unit(16'hD900, 1'b0);
      add_unit(16'h0041, 1'b0);
      add_unit(16'hFFFF, 1'b1);
      add_unit(16'hDA00, 1'b1);
      add_unit(16'hD801, 1'b0);
      add_unit(16'h0000, 1'b1);
      add_unit(16'hD83D, 1'b0);
      add_unit(16'hDE00, 1'b1);
      add_unit(16'h0000, 1'b1);
      drain_all();

      run_phase(0, 0, 80, 1'b0);
      run_phase(77, 0, 80, 1'b0);
      run_phase(0, 77, 80, 1'b0);
      run_phase(33, 33, 80, 1'b0);
      run_phase(0, 0, 80, 1'b1);

      repeat (20) @(posedge clock);
      $display("%0d units sent in directed and random buffers under five idling patterns",
         units_sent);
      $display("%0d items checked: %0d ok and %0d error ends, %0d mismatches",
         results_checked, ok_seen, err_seen, mismatches);
      if (mismatches == 0 && utf8_exp_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_decode.sv
rtl/core/utf16_to_utf8_transcoder_top.sv
tb/tb_top.sv
